/* src/assert_macros.svh */
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/sur_pkg.sv */
// ---------------------------------------------------------------------------
// sur_pkg: shared types and constants for the row sort/dedup block
// Row width, column count, key mapping and the front/back command struct.
// ---------------------------------------------------------------------------
package sur_pkg;
  localparam int unsigned NCOLS  = 4;
  localparam int unsigned EW     = 64;
  localparam int unsigned ROW_W  = NCOLS * EW;
  localparam int unsigned CFG_W  = 3;

  typedef logic [EW-1:0]    elem_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [2:0]       ncol_t;

  // Command from loader to sorter: sort a batch of cnt rows
  typedef struct packed {
    logic [12:0] cnt;
    logic        drop;
  } batch_t;

  // Double bit pattern to unsigned key with numeric order; -0 maps as +0
  function automatic elem_t num_key(input elem_t b);
    elem_t v;
    v = b;
    if (v == {1'b1, {(EW-1){1'b0}}}) v = '0;
    if (v[EW-1]) num_key = ~v;
    else num_key = v | {1'b1, {(EW-1){1'b0}}};
  endfunction

  // Clamp the column count to 1..NCOLS
  function automatic ncol_t used_cols(input logic [CFG_W-1:0] c);
    if (c == '0) used_cols = 3'd1;
    else if (c > CFG_W'(NCOLS)) used_cols = 3'(NCOLS);
    else used_cols = c;
  endfunction

  // Compare of one column pair: keys
  function automatic logic col_lt(input elem_t a, input elem_t b);
    col_lt = num_key(a) < num_key(b);
  endfunction
endpackage

/* src/sur_front.sv */
// ---------------------------------------------------------------------------
// sur_front: row loader
// Appends one row per beat into the row memory, flags dropped rows,
// and posts a batch command into the queue on the final row.
// ---------------------------------------------------------------------------
module sur_front #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned AW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_go,
  input  logic                final_row,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic                post,
  output sur_pkg::batch_t     post_cmd
);
  import sur_pkg::*;

  logic [12:0] cnt_r, cnt_nxt;
  logic        drop_r, drop_nxt;
  logic        full;

  assign full    = cnt_r >= 13'(MAX_ROWS);
  assign wr_en   = in_go && !full;
  assign wr_addr = cnt_r[AW-1:0];
  assign post    = in_go && final_row;

  // batch command reflects this beat
  always_comb begin
    post_cmd.cnt  = full ? cnt_r : cnt_r + 13'd1;
    post_cmd.drop = drop_r | full;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    if (in_go) begin
      if (full) drop_nxt = 1'b1;
      else cnt_nxt = cnt_r + 13'd1;
      if (final_row) begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end
endmodule

/* src/sur_back.sv */
// ---------------------------------------------------------------------------
// sur_back: sorter and emitter
// Sorts row indices with a stable insertion sort, one compare per step
// through registered order-table and row memory reads, then emits
// distinct rows.
// ---------------------------------------------------------------------------
module sur_back #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned AW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  sur_pkg::batch_t     cmd,
  output logic                cmd_take,
  input  logic [2:0]          cols_in_use,
  output logic [AW-1:0]       rd_addr,
  input  sur_pkg::row_t       rd_data,
  output logic                out_strobe,
  output sur_pkg::row_t       out_row,
  output logic                last_out,
  output logic                overflowed
);
  import sur_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INS   = 8'b0000_0010,  // fetch row i
    S_RDJ   = 8'b0000_0100,  // fetch order[j-1]
    S_CMP   = 8'b0000_1000,  // compare and shift
    S_ERD   = 8'b0001_0000,  // fetch order[i]
    S_EWT   = 8'b0010_0000,  // fetch row order[i]
    S_EMIT  = 8'b0100_0000,
    S_RDM   = 8'b1000_0000   // fetch row order[j-1]
  } st_t;

  st_t st_r, st_nxt;
  logic [AW-1:0] order_r [MAX_ROWS];
  logic [AW-1:0] ord_ra, ord_q_r;
  logic [12:0] n_r, i_r, j_r;
  logic        drop_r;
  ncol_t       nc_r;
  row_t        v_row_r, prev_r;
  logic        have_prev_r;
  row_t        pend_r;
  logic        pend_v_r;
  logic        gt;
  logic        eq;

  // lexicographic compare of fetched row (order[j-1]) against v
  always_comb begin
    gt = 1'b0;
    eq = 1'b1;
    for (int k = 0; k < NCOLS; k++) begin
      if (eq && 3'(k) < nc_r) begin
        if (col_lt(v_row_r[k*EW +: EW], rd_data[k*EW +: EW])) begin
          gt = 1'b1; eq = 1'b0;
        end else if (col_lt(rd_data[k*EW +: EW], v_row_r[k*EW +: EW])) begin
          eq = 1'b0;
        end
      end
    end
  end

  // dedup compare of fetched row against previous emitted one
  logic same;
  always_comb begin
    same = 1'b1;
    for (int k = 0; k < NCOLS; k++)
      if (3'(k) < nc_r && num_key(prev_r[k*EW +: EW]) != num_key(rd_data[k*EW +: EW]))
        same = 1'b0;
  end

  assign cmd_take = (st_r == S_IDLE) && cmd_valid;

  // order table read port: order[i] while emitting, order[j-1] while sorting
  always_comb begin
    if (st_r == S_ERD || st_r == S_EWT || st_r == S_EMIT) ord_ra = i_r[AW-1:0];
    else ord_ra = j_r[AW-1:0] - AW'(1);
  end

  always_ff @(posedge clk) begin
    ord_q_r <= order_r[ord_ra];
  end

  always_comb begin
    rd_addr = i_r[AW-1:0];
    case (st_r)
      S_RDM:  rd_addr = ord_q_r;
      S_EWT:  rd_addr = ord_q_r;
      default: rd_addr = i_r[AW-1:0];
    endcase
  end

  row_t masked;
  always_comb begin
    masked = rd_data;
    for (int k = 0; k < NCOLS; k++)
      if (3'(k) >= nc_r) masked[k*EW +: EW] = '0;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (cmd_valid) st_nxt = S_INS;
      S_INS: begin
        if (i_r >= n_r) st_nxt = S_ERD;
        else if (i_r == '0) st_nxt = S_INS;
        else st_nxt = S_RDJ;
      end
      S_RDJ:  st_nxt = (j_r == '0) ? S_INS : S_RDM;
      S_RDM:  st_nxt = S_CMP;
      S_CMP:  st_nxt = gt ? S_RDJ : S_INS;
      S_ERD:  st_nxt = (i_r >= n_r) ? S_IDLE : S_EWT;
      S_EWT:  st_nxt = S_EMIT;
      S_EMIT: st_nxt = S_ERD;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_strobe <= 1'b0;
      pend_v_r <= 1'b0;
      have_prev_r <= 1'b0;
      i_r <= '0; j_r <= '0; n_r <= '0;
    end else begin
      out_strobe <= 1'b0;
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: if (cmd_valid) begin
          n_r <= cmd.cnt; drop_r <= cmd.drop; nc_r <= used_cols(cols_in_use);
          i_r <= '0; pend_v_r <= 1'b0; have_prev_r <= 1'b0;
        end
        S_INS: begin
          j_r <= i_r;
          if (i_r >= n_r) i_r <= '0;
          else if (i_r == '0) begin
            order_r[0] <= '0; i_r <= 13'd1;
          end
        end
        S_RDJ: begin
          if (j_r == '0) begin
            order_r[j_r[AW-1:0]] <= i_r[AW-1:0];
            i_r <= i_r + 13'd1;
          end
        end
        S_CMP: begin
          if (gt) begin
            order_r[j_r[AW-1:0]] <= ord_q_r;
            j_r <= j_r - 13'd1;
          end else begin
            order_r[j_r[AW-1:0]] <= i_r[AW-1:0];
            i_r <= i_r + 13'd1;
          end
        end
        S_ERD: if (i_r >= n_r) begin
          if (pend_v_r) begin
            out_strobe <= 1'b1; out_row <= pend_r; last_out <= 1'b1;
            overflowed <= drop_r;
          end
        end
        S_EMIT: begin
          if (!have_prev_r || !same) begin
            if (pend_v_r) begin
              out_strobe <= 1'b1; out_row <= pend_r; last_out <= 1'b0;
              overflowed <= drop_r;
            end
            pend_r <= masked; pend_v_r <= 1'b1;
            prev_r <= rd_data; have_prev_r <= 1'b1;
          end
          i_r <= i_r + 13'd1;
        end
        default: ;
      endcase
    end
  end

  // v row latches fetched row i
  always_ff @(posedge clk) begin
    if (st_r == S_RDJ && j_r == i_r) v_row_r <= rd_data;
  end
endmodule

/* src/sur_queue.sv */
// ---------------------------------------------------------------------------
// sur_queue: one-entry command queue and row memory
// Holds batch commands between loader and sorter; the row memory has one
// write port (loader) and one registered read port (sorter).
// ---------------------------------------------------------------------------
module sur_queue #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned AW = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sur_pkg::batch_t push_cmd,
  input  logic            pop,
  output logic            q_valid,
  output logic            q_full,
  output sur_pkg::batch_t q_cmd,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  sur_pkg::row_t   wr_data,
  input  logic [AW-1:0]   rd_addr,
  output sur_pkg::row_t   rd_data
);
  import sur_pkg::*;

  row_t   mem [MAX_ROWS];
  batch_t slot_r;
  logic   v_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // one-deep command slot
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (push) begin
      v_r <= 1'b1; slot_r <= push_cmd;
    end else if (pop) v_r <= 1'b0;
  end

  assign q_valid = v_r;
  assign q_full  = v_r;
  assign q_cmd   = slot_r;
endmodule

/* src/sort_unique_rows.sv */
// ---------------------------------------------------------------------------
// sort_unique_rows: lexicographic row sort with deduplication
// Loads rows, sorts them ascending over the used columns, emits each
// distinct row once with the last result flagged.
// ---------------------------------------------------------------------------
// channel  | ports                          | handshake
// input    | in_elem_a..d, in_final_row     | start & !busy
// result   | out_a..d, out_last_out, ovf    | out_strobe, one cycle
// config   | cfg_we, cfg_wdata              | cfg_we
// Loading accepts one row per cycle while busy is low. After the final row
// the sorter runs an insertion sort, each compare going through order read,
// row read and compare; then each row passes order read, row read and emit,
// and distinct rows are sent.
// busy is high from the final row until the answer is out.
// Reset is synchronous; the row memory is not cleared. Results cannot stall.
module sort_unique_rows #(
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_elem_a,
  input  logic [63:0] in_elem_b,
  input  logic [63:0] in_elem_c,
  input  logic [63:0] in_elem_d,
  input  logic        in_final_row,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [63:0] out_a,
  output logic [63:0] out_b,
  output logic [63:0] out_c,
  output logic [63:0] out_d,
  output logic        out_last_out,
  output logic        out_overflowed
);
  import sur_pkg::*;
  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [2:0] cols_r;
  logic in_go, wr_en, post, q_valid, q_full, take, bk_busy_r;
  logic [AW-1:0] wr_addr, rd_addr;
  batch_t post_cmd, q_cmd;
  row_t rd_data, out_row;

  always_ff @(posedge clk) begin
    if (!rst_n) cols_r <= 3'd4;
    else if (cfg_we) cols_r <= cfg_wdata;
  end

  // busy covers the whole sort/emit so the memory is not overwritten
  always_ff @(posedge clk) begin
    if (!rst_n) bk_busy_r <= 1'b0;
    else if (post) bk_busy_r <= 1'b1;
    else if (out_strobe && out_last_out) bk_busy_r <= 1'b0;
    else if (take && q_cmd.cnt == '0) bk_busy_r <= 1'b0;
  end
  assign busy  = bk_busy_r || q_full;
  assign in_go = start && !busy;

  sur_front #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_front (
    .clk, .rst_n, .in_go, .final_row(in_final_row),
    .wr_en, .wr_addr, .post, .post_cmd);

  sur_queue #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_queue (
    .clk, .rst_n, .push(post), .push_cmd(post_cmd), .pop(take),
    .q_valid, .q_full, .q_cmd, .wr_en, .wr_addr,
    .wr_data({in_elem_d, in_elem_c, in_elem_b, in_elem_a}),
    .rd_addr, .rd_data);

  sur_back #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd(q_cmd), .cmd_take(take),
    .cols_in_use(cols_r), .rd_addr, .rd_data, .out_strobe, .out_row,
    .last_out(out_last_out), .overflowed(out_overflowed));

  assign out_a = out_row[0*EW +: EW];
  assign out_b = out_row[1*EW +: EW];
  assign out_c = out_row[2*EW +: EW];
  assign out_d = out_row[3*EW +: EW];
endmodule

/* src/sur_checker.sv */
// ---------------------------------------------------------------------------
// sur_checker: port-level checks for sort_unique_rows
// Watches the handshake and result framing at the top level ports.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module sur_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_final_row,
  input logic out_strobe,
  input logic out_last_out
);
  `CHK_NEXT(a_final_busy, clk, rst_n, start && !busy && in_final_row, busy, "no busy after final")
  `CHK_IMPL(a_out_busy, clk, rst_n, out_strobe, busy, "result while idle")
  `CHK_NEXT(a_last_end, clk, rst_n, out_strobe && out_last_out, !out_strobe, "result after last")
endmodule

bind sort_unique_rows sur_checker u_chk (.*);

/* sim/tb_sort_unique_rows.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sort_unique_rows: self-checking bench for the row sort/dedup block
// Loads matrices row by row, predicts the sorted distinct rows in a
// scoreboard class and checks every result beat field by field.
// ---------------------------------------------------------------------------
module tb_sort_unique_rows;
  import sur_pkg::*;

  localparam int unsigned CAP = 64;
  localparam int unsigned WDOG_LIMIT = 200000;

  typedef struct packed {
    elem_t a, b, c, d;
    logic  last, ovf;
  } answer_t;

  logic        clk, rst_n, start, busy;
  logic [63:0] in_elem_a, in_elem_b, in_elem_c, in_elem_d;
  logic        in_final_row, cfg_we;
  logic [2:0]  cfg_wdata;
  logic        out_strobe;
  logic [63:0] out_a, out_b, out_c, out_d;
  logic        out_last_out, out_overflowed;

  int fail_cnt = 0;
  int idle_cycles = 0;

  sort_unique_rows #(.MAX_ROWS(CAP)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_elem_a(in_elem_a), .in_elem_b(in_elem_b), .in_elem_c(in_elem_c),
    .in_elem_d(in_elem_d), .in_final_row(in_final_row),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_a(out_a), .out_b(out_b), .out_c(out_c),
    .out_d(out_d), .out_last_out(out_last_out), .out_overflowed(out_overflowed)
  );

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_cnt++;
  endtask

  // Scoreboard: holds the loaded matrix and the queue of expected rows
  class row_sort_sb;
    elem_t    rows[CAP][4];
    int       n_rows;
    bit       dropped;
    logic [2:0] ncols_reg;
    answer_t  pending[$];

    function new();
      n_rows = 0; dropped = 0; ncols_reg = 3'd4;
    endfunction

    // numeric order key, -0 folds onto +0
    function elem_t order_key(elem_t v);
      if (v == {1'b1, 63'd0}) v = '0;
      return v[63] ? ~v : (v | {1'b1, 63'd0});
    endfunction

    function int row_order(int r, int s, int nc);
      elem_t x, y;
      for (int k = 0; k < nc; k++) begin
        x = order_key(rows[r][k]);
        y = order_key(rows[s][k]);
        if (x < y) return -1;
        if (x > y) return 1;
      end
      return 0;
    endfunction

    // note an accepted row; a final row queues the whole answer
    function void note_row(elem_t a, elem_t b, elem_t c, elem_t d, logic fin);
      int idx[CAP];
      int nc, j, v, cnt;
      answer_t ans;
      if (n_rows >= CAP) dropped = 1;
      else begin
        rows[n_rows][0] = a; rows[n_rows][1] = b;
        rows[n_rows][2] = c; rows[n_rows][3] = d;
        n_rows++;
      end
      if (!fin) return;
      nc = (ncols_reg == 0) ? 1 : (ncols_reg > 4 ? 4 : ncols_reg);
      for (int i = 0; i < n_rows; i++) begin
        v = i; j = i;
        while (j > 0 && row_order(idx[j-1], v, nc) > 0) begin
          idx[j] = idx[j-1]; j--;
        end
        idx[j] = v;
      end
      cnt = 0;
      for (int i = 0; i < n_rows; i++) begin
        if (i > 0 && row_order(idx[i-1], idx[i], nc) == 0) continue;
        ans.a = rows[idx[i]][0];
        ans.b = nc > 1 ? rows[idx[i]][1] : '0;
        ans.c = nc > 2 ? rows[idx[i]][2] : '0;
        ans.d = nc > 3 ? rows[idx[i]][3] : '0;
        ans.last = 0; ans.ovf = dropped;
        pending.push_back(ans);
        cnt++;
      end
      if (cnt > 0) pending[pending.size()-1].last = 1;
      n_rows = 0; dropped = 0;
    endfunction

    task check_beat(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        $display("unexpected result beat at %0t", $time);
        fail_cnt++;
        return;
      end
      want = pending.pop_front();
      if (got.a !== want.a) report("out_a", got.a, want.a);
      if (got.b !== want.b) report("out_b", got.b, want.b);
      if (got.c !== want.c) report("out_c", got.c, want.c);
      if (got.d !== want.d) report("out_d", got.d, want.d);
      if (got.last !== want.last) report("out_last_out", got.last, want.last);
      if (got.ovf !== want.ovf) report("out_overflowed", got.ovf, want.ovf);
    endtask
  endclass

  row_sort_sb sorted_rows_sb = new();

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // sample accepted rows, config writes and result beats; watchdog on idle cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sorted_rows_sb.note_row(in_elem_a, in_elem_b, in_elem_c, in_elem_d, in_final_row);
      if (out_strobe)
        sorted_rows_sb.check_beat({out_a, out_b, out_c, out_d, out_last_out, out_overflowed});
      if (cfg_we) sorted_rows_sb.ncols_reg = cfg_wdata;
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // special element values: zeros, ones, infinities, extremes, NaN, denormals
  function automatic elem_t special_elem();
    case ($urandom_range(0, 11))
      0: return 64'h0000_0000_0000_0000;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h7FF0_0000_0000_0000;
      3: return 64'hFFF0_0000_0000_0000;
      4: return 64'h3FF0_0000_0000_0000;
      5: return 64'hBFF0_0000_0000_0000;
      6: return 64'h7FEF_FFFF_FFFF_FFFF;
      7: return 64'hFFEF_FFFF_FFFF_FFFF;
      8: return 64'h0000_0000_0000_0001;
      9: return 64'h8000_0000_0000_0001;
      10: return 64'h7FF8_0000_0000_0001;
      default: return 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  // mode 0 fully random, mode 1 special values, else a tiny pool so duplicates and ties are common
  function automatic elem_t pick_elem(int mode);
    case (mode)
      0: return {$urandom, $urandom};
      1: return special_elem();
      default: return elem_t'($urandom_range(0, 2)) << 62;
    endcase
  endfunction

  task automatic send_row(input elem_t a, b, c, d, input logic fin);
    in_elem_a <= a; in_elem_b <= b; in_elem_c <= c; in_elem_d <= d;
    in_final_row <= fin;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic pause_start();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // random matrix; a burst-gap pattern governs the sender
  task automatic send_matrix(input int n_rows, input int mode);
    int burst;
    burst = $urandom_range(1, 8);
    for (int i = 0; i < n_rows; i++) begin
      send_row(pick_elem(mode ? $urandom_range(0, 2) : 0),
               pick_elem(mode ? $urandom_range(0, 2) : 0),
               pick_elem(mode ? $urandom_range(0, 2) : 0),
               pick_elem(mode ? $urandom_range(0, 2) : 0), i == n_rows - 1);
      if (--burst == 0) begin
        if ($urandom_range(0, 2) != 0) pause_start();
        burst = $urandom_range(1, 8);
      end
    end
    start <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sorted_rows_sb.pending.size() != 0 || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_cols(input logic [2:0] v);
    cfg_wdata <= v; cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int sent;
    rst_n = 0; start = 0; cfg_we = 0; cfg_wdata = '0;
    in_elem_a = '0; in_elem_b = '0; in_elem_c = '0; in_elem_d = '0;
    in_final_row = 0;
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: signed zeros, duplicates, extremes, single-row matrix
    send_row(64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h0, 1'b0);
    send_row(64'h0, 64'h0, 64'h0, 64'h0, 1'b0);
    send_row(64'h7FF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h2, 1'b0);
    send_row(64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'h3, 64'h4, 1'b0);
    send_row(64'h7FF8_0000_0000_0001, 64'h0, 64'h0, 64'h0, 1'b0);
    send_row(64'hFFF8_0000_0000_0001, 64'h0, 64'h0, 64'h0, 1'b0);
    send_row(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    drain();
    send_row(64'h3FF0_0000_0000_0000, 64'h5, 64'h6, 64'h7, 1'b1);
    drain();

    // out-of-range column counts: 0 acts as 1, above 4 acts as 4
    write_cols(3'd0);
    send_matrix(6, 1); drain();
    write_cols(3'd7);
    send_matrix(6, 1); drain();

    // capacity overflow including a dropped final row
    write_cols(3'd2);
    send_matrix(CAP + 1, 2); drain();

    // random phases across column settings
    sent = 0;
    while (sent < 60) begin
      int n;
      write_cols(3'($urandom_range(0, 7)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      send_matrix(n, $urandom_range(0, 2));
      sent += n;
      drain();
    end
    write_cols(3'd1);
    send_matrix(8, 1); drain();
    write_cols(3'd4);
    send_matrix(8, 1); drain();

    if (fail_cnt == 0 && sorted_rows_sb.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
